>>> hw/rtl/btcs_pkg.sv
// Package with shared types and constants of the bigram table coherence scorer.
package btcs_pkg;

  localparam int unsigned TableEntriesDef = 128;
  localparam int unsigned SuccessorsDef   = 10;
  localparam int unsigned ContextDepthDef = 10;
  localparam int unsigned WordBitsDef     = 16;
  localparam int unsigned PortWordBits    = 16;
  localparam int unsigned CohBits         = 7;
  localparam logic [15:0] CountMax        = 16'hFFFF;
  localparam logic [6:0]  FullScore       = 7'd100;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_NEW_KEY,
    ST_SUC_RD,
    ST_SUC_CMP,
    ST_SUC_INC,
    ST_SUC_ADD,
    ST_BEST_RD,
    ST_BEST_CMP,
    ST_BEST_WRD,
    ST_BEST_WCMP,
    ST_COH_NEXT,
    ST_DIV,
    ST_OUT
  } btcs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;     // capture the input word and set up the job
    logic key_rd;       // read key memory at the scan pointer
    logic key_step;     // advance the key scan pointer
    logic key_alloc;    // write a new key
    logic suc_rd;       // read successor memories at the slot pointer
    logic suc_step;     // advance the slot pointer
    logic suc_inc;      // increment matched count
    logic suc_add;      // append a successor
    logic best_upd;     // compare slot count against best
    logic bword_rd;     // read the best successor's word
    logic start_lookup; // set lookup word and clear scan
    logic coh_step;     // record a coherence hit and move to next pair
    logic div_start;    // load divider
    logic div_step;     // one divider step
    logic out_load;     // load the output register
  } btcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic first;
    logic last;
    logic key_end;      // scan pointer reached the key count
    logic key_hit;      // key read data matches
    logic table_full;
    logic suc_end;      // slot pointer reached the used count
    logic suc_hit;
    logic suc_room;     // a free successor slot remains
    logic coh_more;     // more context pairs to score
    logic short_ctx;    // fewer than two context words
    logic div_done;
    logic out_busy;     // output register full and stalled
  } btcs_stat_t;

endpackage

>>> hw/rtl/btcs_ctrl.sv
// Controller state machine of the bigram table coherence scorer.
module btcs_ctrl import btcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  btcs_stat_t stat_i,
  output btcs_cmd_t  cmd_o
);

  btcs_state_e state_q, state_d;
  logic        learn_q, learn_d; // lookup is for learning, not scoring/predict

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      learn_q <= 1'b0;
    end else begin
      state_q <= state_d;
      learn_q <= learn_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    learn_d    = learn_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        // The first cycle after latch decides the flow: a predict word looks up
        // without learning, and a word that opens a sentence learns nothing.
        if (learn_q && (stat_i.mode || stat_i.first)) begin
          learn_d = 1'b0;
          state_d = stat_i.mode ? ST_KEY_RD : ST_COH_NEXT;
        end else if (stat_i.key_end) begin
          if (learn_q) begin
            state_d = stat_i.table_full ? ST_COH_NEXT : ST_NEW_KEY;
          end else begin
            state_d = ST_BEST_CMP; // not found: no successor
          end
        end else begin
          cmd_o.key_rd = 1'b1;
          state_d      = ST_KEY_CMP;
        end
      end
      ST_KEY_CMP: begin
        if (stat_i.key_hit) begin
          state_d = learn_q ? ST_SUC_RD : ST_BEST_RD;
        end else begin
          cmd_o.key_step = 1'b1;
          state_d        = ST_KEY_RD;
        end
      end
      ST_NEW_KEY: begin
        cmd_o.key_alloc = 1'b1;
        state_d         = ST_SUC_RD;
      end
      ST_SUC_RD: begin
        if (stat_i.suc_end) begin
          state_d = stat_i.suc_room ? ST_SUC_ADD : ST_COH_NEXT;
        end else begin
          cmd_o.suc_rd = 1'b1;
          state_d      = ST_SUC_CMP;
        end
      end
      ST_SUC_CMP: begin
        if (stat_i.suc_hit) begin
          state_d = ST_SUC_INC;
        end else begin
          cmd_o.suc_step = 1'b1;
          state_d        = ST_SUC_RD;
        end
      end
      ST_SUC_INC: begin
        cmd_o.suc_inc = 1'b1;
        state_d       = ST_COH_NEXT;
      end
      ST_SUC_ADD: begin
        cmd_o.suc_add = 1'b1;
        state_d       = ST_COH_NEXT;
      end
      ST_BEST_RD: begin
        if (stat_i.suc_end) begin
          cmd_o.bword_rd = 1'b1;
          state_d        = ST_BEST_WRD;
        end else begin
          cmd_o.suc_rd = 1'b1;
          state_d      = ST_BEST_CMP;
        end
      end
      ST_BEST_CMP: begin
        // Also entered when the key is missing; best stays zero then.
        cmd_o.best_upd = 1'b1;
        cmd_o.suc_step = 1'b1;
        state_d        = stat_i.key_end ? ST_BEST_WCMP : ST_BEST_RD;
      end
      ST_BEST_WRD: begin
        state_d = ST_BEST_WCMP;
      end
      ST_BEST_WCMP: begin
        if (stat_i.mode) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.coh_step = 1'b1;
          state_d        = ST_COH_NEXT;
        end
      end
      ST_COH_NEXT: begin
        learn_d = 1'b0;
        if (!stat_i.last || stat_i.short_ctx) begin
          state_d = ST_OUT;
        end else if (stat_i.coh_more) begin
          cmd_o.start_lookup = 1'b1;
          state_d            = ST_KEY_RD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = stat_i.mode | stat_i.last;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd_o.latch_in) learn_d = 1'b1;
  end

endmodule

>>> hw/rtl/btcs_dp.sv
// Datapath of the bigram table coherence scorer: memories, context, divider.
module btcs_dp import btcs_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef,
  parameter int unsigned Successors   = SuccessorsDef,
  parameter int unsigned ContextDepth = ContextDepthDef,
  parameter int unsigned WordBits     = WordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    mode_i,
  input  logic [PortWordBits-1:0] word_i,
  input  logic                    first_of_sentence_i,
  input  logic                    last_of_sentence_i,
  input  btcs_cmd_t               cmd_i,
  output btcs_stat_t              stat_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    kind_o,
  output logic [PortWordBits-1:0] next_word_o,
  output logic                    found_o,
  output logic [CohBits-1:0]      coherence_o
);

  localparam int unsigned KeyW  = $clog2(TableEntries);
  localparam int unsigned KcW   = $clog2(TableEntries + 1);
  localparam int unsigned SucW  = $clog2(Successors + 1);
  localparam int unsigned SlotW = (Successors > 1) ? $clog2(Successors) : 1;
  localparam int unsigned CtxW  = $clog2(ContextDepth + 1);
  localparam int unsigned CtxIW = $clog2(ContextDepth);
  localparam int unsigned SDepth = TableEntries * Successors;
  localparam int unsigned SAddrW = $clog2(SDepth);
  localparam int unsigned HitW  = CtxW;
  localparam int unsigned NumW  = HitW + 7;

  // Memories. A key's used count is cleared when the key is allocated.
  logic [WordBits-1:0] key_mem  [TableEntries];
  logic [WordBits-1:0] sw_mem   [SDepth];
  logic [15:0]         sc_mem   [SDepth];
  logic [SucW-1:0]     used_mem [TableEntries];

  logic [WordBits-1:0] ctx_q [ContextDepth];
  logic [CtxW-1:0]     ctx_len_q;
  logic [WordBits-1:0] prev_q;
  logic [KcW-1:0]      key_count_q;

  logic                mode_q, first_q, last_q;
  logic [WordBits-1:0] look_q;    // key being looked up
  logic [WordBits-1:0] target_q;  // successor being learned, or next context word
  logic [KcW-1:0]      kptr_q;
  logic [KeyW-1:0]     kidx_q;
  logic [SucW-1:0]     used_rd_q; // used count of the key at kidx_q
  logic [SucW-1:0]     sptr_q;
  logic [WordBits-1:0] krd_q, swrd_q;
  logic [15:0]         scrd_q, best_q;
  logic [SlotW-1:0]    bidx_q;
  logic [CtxIW-1:0]    cpos_q;    // first word of the pair being scored
  logic [HitW-1:0]     hits_q;
  logic [NumW-1:0]     rem_q;
  logic [6:0]          quo_q;
  logic [2:0]          dcnt_q;
  logic                out_v_q, out_kind_q, out_found_q;
  logic [PortWordBits-1:0] out_word_q;
  logic [CohBits-1:0]  out_coh_q;

  logic [WordBits-1:0] in_word;
  logic [SAddrW-1:0]   s_addr;
  logic [SucW-1:0]     used_k;
  logic [CtxW-1:0]     pairs;
  logic [NumW-1:0]     dsor_sh;
  logic                found_w;

  assign in_word = WordBits'(word_i);
  assign used_k  = used_rd_q;
  assign s_addr  = SAddrW'(kidx_q * Successors) + SAddrW'(sptr_q[SlotW-1:0]);
  assign pairs   = ctx_len_q - CtxW'(1);
  assign dsor_sh = NumW'(pairs) << dcnt_q;
  assign found_w = (best_q != 16'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_rd) begin
      krd_q     <= key_mem[kptr_q[KeyW-1:0]];
      used_rd_q <= used_mem[kptr_q[KeyW-1:0]];
    end
    if (cmd_i.key_alloc) begin
      key_mem[key_count_q[KeyW-1:0]]  <= look_q;
      used_mem[key_count_q[KeyW-1:0]] <= '0;
      used_rd_q                       <= '0;
    end
    if (cmd_i.suc_add) used_mem[kidx_q] <= used_rd_q + SucW'(1);
    if (cmd_i.suc_rd || cmd_i.bword_rd) begin
      swrd_q <= sw_mem[cmd_i.bword_rd ? SAddrW'(kidx_q * Successors) + SAddrW'(bidx_q)
                                      : s_addr];
      scrd_q <= sc_mem[s_addr];
    end
    if (cmd_i.suc_inc && scrd_q != CountMax) sc_mem[s_addr] <= scrd_q + 16'd1;
    if (cmd_i.suc_add) begin
      sw_mem[s_addr] <= target_q;
      sc_mem[s_addr] <= 16'd1;
    end
  end

  // Context window, payload only; length is control.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in && !mode_i) begin
      if (ctx_len_q == CtxW'(ContextDepth)) begin
        for (int i = 0; i < ContextDepth - 1; i++) ctx_q[i] <= ctx_q[i+1];
        ctx_q[ContextDepth-1] <= in_word;
      end else begin
        ctx_q[ctx_len_q[CtxIW-1:0]] <= in_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_len_q   <= '0;
      prev_q      <= '0;
      key_count_q <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (cmd_i.latch_in && !mode_i) begin
        if (ctx_len_q != CtxW'(ContextDepth)) ctx_len_q <= ctx_len_q + CtxW'(1);
        prev_q <= in_word;
      end
      if (cmd_i.key_alloc) key_count_q <= key_count_q + KcW'(1);
      if (cmd_i.out_load) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q   <= mode_i;
      first_q  <= first_of_sentence_i;
      last_q   <= last_of_sentence_i;
      look_q   <= mode_i ? in_word : prev_q;
      target_q <= in_word;
      kptr_q   <= '0;
      sptr_q   <= '0;
      best_q   <= '0;
      bidx_q   <= '0;
      cpos_q   <= '0;
      hits_q   <= '0;
    end
    if (cmd_i.start_lookup) begin
      look_q   <= ctx_q[cpos_q];
      target_q <= ctx_q[cpos_q + CtxIW'(1)];
      kptr_q   <= '0;
      sptr_q   <= '0;
      best_q   <= '0;
      bidx_q   <= '0;
    end
    if (cmd_i.key_step) kptr_q <= kptr_q + KcW'(1);
    if (cmd_i.key_alloc) kidx_q <= key_count_q[KeyW-1:0];
    else if (cmd_i.key_rd) kidx_q <= kptr_q[KeyW-1:0];
    if (cmd_i.suc_step) sptr_q <= sptr_q + SucW'(1);
    if (cmd_i.best_upd && !stat_o.key_end && scrd_q > best_q) begin
      best_q <= scrd_q;
      bidx_q <= sptr_q[SlotW-1:0];
    end
    if (cmd_i.coh_step) begin
      if (found_w && swrd_q == target_q) hits_q <= hits_q + HitW'(1);
      cpos_q <= cpos_q + CtxIW'(1);
    end
    // Restoring division of hits*100 by the pair count, one quotient bit a step.
    if (cmd_i.div_start) begin
      rem_q  <= NumW'(hits_q) * NumW'(100);
      quo_q  <= '0;
      dcnt_q <= 3'd6;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dsor_sh) begin
        rem_q <= rem_q - dsor_sh;
        quo_q <= quo_q | (7'd1 << dcnt_q);
      end
      dcnt_q <= dcnt_q - 3'd1;
    end
    if (cmd_i.out_load) begin
      out_kind_q  <= !mode_q;
      out_found_q <= mode_q && found_w;
      out_word_q  <= (mode_q && found_w) ? PortWordBits'(swrd_q) : '0;
      out_coh_q   <= mode_q ? '0 : (ctx_len_q < CtxW'(2)) ? FullScore : quo_q;
    end
  end

  // div_done is set once the last step has run; track with a flag.
  logic div_busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_busy_q <= 1'b0;
    else if (cmd_i.div_start) div_busy_q <= 1'b1;
    else if (cmd_i.div_step && dcnt_q == 3'd0) div_busy_q <= 1'b0;
  end

  always_comb begin
    stat_o            = '0;
    stat_o.mode       = mode_q;
    stat_o.first      = first_q;
    stat_o.last       = last_q;
    stat_o.key_end    = (kptr_q >= key_count_q);
    stat_o.key_hit    = (krd_q == look_q);
    stat_o.table_full = (key_count_q == KcW'(TableEntries));
    stat_o.suc_end    = (sptr_q >= used_k);
    stat_o.suc_hit    = (swrd_q == target_q);
    stat_o.suc_room   = (used_k < SucW'(Successors));
    stat_o.coh_more   = (CtxW'(cpos_q) + CtxW'(1) < ctx_len_q);
    stat_o.short_ctx  = (ctx_len_q < CtxW'(2));
    stat_o.div_done   = !div_busy_q;
    stat_o.out_busy   = out_v_q && out_stall_i;
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = out_kind_q;
  assign next_word_o = out_word_q;
  assign found_o     = out_found_q;
  assign coherence_o = out_coh_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= KcW'(TableEntries))
    else $error("key count beyond table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_len_q <= CtxW'(ContextDepth))
    else $error("context length beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.suc_add |-> used_k < SucW'(Successors))
    else $error("successor append with no free slot");

endmodule

>>> hw/rtl/bigram_table_coherence_scorer.sv
// Top level of the bigram table coherence scorer.
// The block takes one word at a time. A feed word enters the context window of the
// last ten words and, unless it opens a sentence, teaches the pair (previous word,
// word) to a table of up to 128 keys with ten counted successors each. A word that
// ends a sentence yields a coherence word: the share in percent of context pairs
// whose second word is the first word's most frequent successor. A predict word
// yields the most frequent successor. Items are handled one at a time; a lookup
// scans the stored keys and then the used successor slots of the matching key,
// entry by entry, in the single-port key and successor memories. A coherence
// result adds a lookup for each context pair and a restoring division. Results
// wait in an output register, and a stalled result holds the block in place.
module bigram_table_coherence_scorer import btcs_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef,
  parameter int unsigned Successors   = SuccessorsDef,
  parameter int unsigned ContextDepth = ContextDepthDef,
  parameter int unsigned WordBits     = WordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic [PortWordBits-1:0] word_i,
  input  logic                    first_of_sentence_i,
  input  logic                    last_of_sentence_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    kind_o,
  output logic [PortWordBits-1:0] next_word_o,
  output logic                    found_o,
  output logic [CohBits-1:0]      coherence_o
);

  btcs_cmd_t  cmd;
  btcs_stat_t stat;

  btcs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  btcs_dp #(
    .TableEntries (TableEntries),
    .Successors   (Successors),
    .ContextDepth (ContextDepth),
    .WordBits     (WordBits)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .mode_i,
    .word_i,
    .first_of_sentence_i,
    .last_of_sentence_i,
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .next_word_o,
    .found_o,
    .coherence_o
  );

endmodule

>>> verif/tb_top.sv
// Testbench for the bigram table coherence scorer: self-checking stimulus and checking.
module tb_top;
  import btcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Keys      = TableEntriesDef;
  localparam int unsigned Slots     = SuccessorsDef;
  localparam int unsigned Depth     = ContextDepthDef;
  localparam int unsigned IdleLimit = 200000;

  localparam logic ModeFeed    = 1'b0;
  localparam logic ModePredict = 1'b1;
  localparam logic KindPredict = 1'b0;
  localparam logic KindScore   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] next_word;
    logic        found;
    logic [6:0]  coherence;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [15:0] word_i = '0;
  logic        first_of_sentence_i = 1'b0;
  logic        last_of_sentence_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [15:0] next_word_o;
  logic        found_o;
  logic [6:0]  coherence_o;

  always #1 clk_i = ~clk_i;

  bigram_table_coherence_scorer uut (.*);

  // Shadow copy of the bigram table and the context window.
  logic [15:0] sh_key [Keys];
  int unsigned sh_keys;
  logic [15:0] sh_sw [Keys][Slots];
  logic [15:0] sh_sc [Keys][Slots];
  int unsigned sh_used [Keys];
  logic [15:0] sh_ctx [Depth];
  int unsigned sh_ctx_len;
  logic [15:0] sh_prev;

  answer_t     pending_answers[$];
  int unsigned errors, words_sent, answers_seen, scores_seen;
  int unsigned idle_cycles;
  bit          no_gaps, hold_receiver;

  function automatic int find_key(logic [15:0] w);
    for (int i = 0; i < int'(sh_keys); i++) if (sh_key[i] == w) return i;
    return -1;
  endfunction

  // Most frequent successor; the lowest slot wins a tie.
  function automatic bit best_successor(logic [15:0] w, output logic [15:0] nxt);
    int k;
    logic [15:0] best;
    int idx;
    k = find_key(w);
    nxt = '0;
    best = '0;
    idx = 0;
    if (k < 0) return 1'b0;
    for (int j = 0; j < int'(sh_used[k]); j++) begin
      if (sh_sc[k][j] > best) begin
        best = sh_sc[k][j];
        idx = j;
      end
    end
    if (best == 0) return 1'b0;
    nxt = sh_sw[k][idx];
    return 1'b1;
  endfunction

  function automatic void learn_bigram(logic [15:0] from, logic [15:0] to);
    int k;
    k = find_key(from);
    if (k < 0) begin
      if (sh_keys >= Keys) return;  // a full table drops the new key
      k = sh_keys;
      sh_key[k] = from;
      sh_used[k] = 0;
      sh_keys++;
    end
    for (int j = 0; j < int'(sh_used[k]); j++) begin
      if (sh_sw[k][j] == to) begin
        if (sh_sc[k][j] != CountMax) sh_sc[k][j]++;
        return;
      end
    end
    if (sh_used[k] < Slots) begin
      sh_sw[k][sh_used[k]] = to;
      sh_sc[k][sh_used[k]] = 16'd1;
      sh_used[k]++;
    end
  endfunction

  function automatic logic [6:0] score_context();
    int unsigned hits;
    logic [15:0] nxt;
    hits = 0;
    if (sh_ctx_len < 2) return FullScore;
    for (int i = 0; i + 1 < int'(sh_ctx_len); i++)
      if (best_successor(sh_ctx[i], nxt) && nxt == sh_ctx[i+1]) hits++;
    return 7'((hits * 100) / (sh_ctx_len - 1));
  endfunction

  // Advances the shadow state by one word and queues the answer it causes.
  function automatic void predict_answer(logic m, logic [15:0] w, logic f, logic l);
    answer_t a;
    logic [15:0] nxt;
    a = '0;
    if (m == ModePredict) begin
      a.kind = KindPredict;
      a.found = best_successor(w, nxt);
      a.next_word = a.found ? nxt : '0;
      pending_answers.push_back(a);
      return;
    end
    if (sh_ctx_len >= Depth) begin
      for (int i = 0; i + 1 < int'(Depth); i++) sh_ctx[i] = sh_ctx[i+1];
      sh_ctx[Depth-1] = w;
    end else begin
      sh_ctx[sh_ctx_len] = w;
      sh_ctx_len++;
    end
    if (!f) learn_bigram(sh_prev, w);
    sh_prev = w;
    if (l) begin
      a.kind = KindScore;
      a.coherence = score_context();
      pending_answers.push_back(a);
    end
  endfunction

  // Offers one word and waits until the block takes it. Valid drops only in a
  // gap, so a following word can be offered in the very cycle of the accept.
  task automatic send_word(logic m, logic [15:0] w, logic f, logic l);
    while (!no_gaps && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    word_i <= w;
    first_of_sentence_i <= f;
    last_of_sentence_i <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_answer(m, w, f, l);
    words_sent++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on answer %0d: %s got %0d expected %0d", answers_seen, what, got, want);
    errors++;
  endtask

  // Receiver stalls.
  always @(posedge clk_i) begin
    if (hold_receiver) out_stall_i <= 1'b1;
    else out_stall_i <= !no_gaps && ($urandom_range(99) < 35);
  end

  // Checks each accepted answer against the oldest prediction.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        $display("answer with nothing expected");
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
        if (next_word_o !== want.next_word)
          report_mismatch("next_word", next_word_o, want.next_word);
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (coherence_o !== want.coherence)
          report_mismatch("coherence", coherence_o, want.coherence);
        if (want.kind == KindScore) scores_seen++;
      end
      answers_seen++;
    end
  end

  // Watchdog over cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("** bigram_table_coherence_scorer: FAILED **");
      $finish;
    end
  end

  // Short sentences, extremes of the word, predictions and ties.
  task automatic test_directed();
    send_word(ModeFeed, 16'h0000, 1'b1, 1'b1);   // lone word scores full
    send_word(ModePredict, 16'hFFFF, 1'b1, 1'b1); // unknown word, flags ignored
    send_word(ModeFeed, 16'hFFFF, 1'b0, 1'b0);
    send_word(ModeFeed, 16'h0001, 1'b0, 1'b0);
    send_word(ModeFeed, 16'hFFFF, 1'b0, 1'b1);
    send_word(ModePredict, 16'h0000, 1'b0, 1'b0);
    send_word(ModePredict, 16'hFFFF, 1'b0, 1'b0);
    // Tie: 7 -> 8 and 7 -> 9 once each; the first slot wins.
    send_word(ModeFeed, 16'h0007, 1'b1, 1'b0);
    send_word(ModeFeed, 16'h0008, 1'b0, 1'b0);
    send_word(ModeFeed, 16'h0007, 1'b1, 1'b0);
    send_word(ModeFeed, 16'h0009, 1'b0, 1'b1);
    send_word(ModePredict, 16'h0007, 1'b0, 1'b0);
    // Twenty-four words cycle the window past its depth and overfill one key's slots.
    for (int i = 0; i < 24; i++)
      send_word(ModeFeed, (i % 2) ? 16'h0050 : 16'h0040 + 16'(i), 1'b0, i == 23);
    send_word(ModePredict, 16'h0050, 1'b0, 1'b0);
  endtask

  // Sentences from a small vocabulary so scores and predictions are meaningful.
  task automatic test_random_sentences(int unsigned n);
    int unsigned len, pos;
    logic [15:0] w;
    len = 0;
    pos = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20) begin
        w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
        send_word(ModePredict, w, 1'($urandom), 1'($urandom));
      end else begin
        if (pos == 0) len = $urandom_range(1, 14);
        w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(15));
        if ($urandom_range(19) == 0) w = 16'hFFFF;
        send_word(ModeFeed, w, pos == 0 || $urandom_range(29) == 0, pos + 1 == len);
        pos = (pos + 1 == len) ? 0 : pos + 1;
      end
    end
  endtask

  // Many distinct keys overflow the table; later keys are dropped.
  task automatic test_table_full();
    for (int i = 0; i < int'(Keys) + 12; i++)
      send_word(ModeFeed, 16'h1000 + 16'(i), 1'b0, i % 40 == 39);
    send_word(ModePredict, 16'h1000 + 16'(Keys + 5), 1'b0, 1'b0);
    send_word(ModePredict, 16'h1005, 1'b0, 1'b0);
  endtask

  // Receiver holds off while words keep coming, so the block backs up.
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_receiver = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_word(ModePredict, 16'($urandom_range(15)), 1'b0, 1'b0);
    join
  endtask

  // Gapless stretch on both sides.
  task automatic test_no_idling();
    no_gaps = 1'b1;
    test_random_sentences(100);
    no_gaps = 1'b0;
  endtask

  initial begin
    int unsigned drain;
    errors = 0;
    words_sent = 0;
    answers_seen = 0;
    scores_seen = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    hold_receiver = 1'b0;
    sh_keys = 0;
    sh_ctx_len = 0;
    sh_prev = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sentences(400);
    test_backpressure();
    test_no_idling();
    test_table_full();
    test_random_sentences(100);
    in_valid_i <= 1'b0;
    drain = 0;
    while (pending_answers.size() != 0 && drain < IdleLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words, checked %0d answers of which %0d were coherence scores;",
             words_sent, answers_seen, scores_seen);
    $display("covered table overflow, tie breaks, window wrap and a long output stall.");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("** bigram_table_coherence_scorer: PASSED **");
    end else begin
      $display("%0d mismatches, %0d answers missing", errors, pending_answers.size());
      $display("** bigram_table_coherence_scorer: FAILED **");
    end
    $finish;
  end
endmodule
